// ===== sv/acyclic_component_counter_macros.svh =====
// Assertion macros used by the checker of the acyclic component counter.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef ACYCLIC_COMPONENT_COUNTER_MACROS_SVH
`define ACYCLIC_COMPONENT_COUNTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ACC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ACC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== sv/acc_pkg.sv =====
package acc_pkg;

   // Widths fixed by the interface.
   localparam int NODE_W  = 10;
   localparam int COUNT_W = 10;

   // Request codes carried by req_type.
   localparam logic REQ_EDGE = 1'b0;
   localparam logic REQ_END  = 1'b1;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FIND_P,
      ST_FIND_GP,
      ST_UPDATE,
      ST_LINK
   } state_type;

endpackage

// ===== sv/acyclic_component_counter.sv =====
// Counts the connected components without a cycle in an undirected graph that
// arrives one edge per word, followed by an end word that returns the count.
// The forest is kept as union-find links in one single-port-read, single-port-
// write memory, each entry holding a parent index and a cycle flag for roots.
// An out-of-range edge is only flagged. A good edge runs a root search for
// each endpoint, reading one entry per step with path halving, then an update,
// and a link write when two trees merge. An end word is taken and is
// followed by a clearing pass that rewrites every entry; the same pass runs
// after reset. Busy is high whenever the block is not idle, and start is
// taken only while idle, so no new word is taken before the last is done.
// The result appears
// on rsp_valid for exactly one cycle, the cycle after the end word, and the
// receiver cannot stall it, so it must capture it then. The configuration
// port is always ready; write node_count only while the block is idle.
module acyclic_component_counter #(
   parameter int MAX_NODES = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   // Command channel.
   input  logic                           start,
   output logic                           busy,
   input  logic                           req_type,
   input  logic [acc_pkg::NODE_W-1:0]     req_node_a,
   input  logic [acc_pkg::NODE_W-1:0]     req_node_b,
   // Result channel.
   output logic                           rsp_valid,
   output logic [acc_pkg::COUNT_W-1:0]    rsp_tree_count,
   output logic                           rsp_bad_edge_seen,
   // Configuration channel.
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [acc_pkg::NODE_W-1:0]     csr_node_count
);

   localparam int AW       = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
   localparam int CAP      = (MAX_NODES > 1023) ? 1023 : MAX_NODES;
   localparam int NW       = acc_pkg::NODE_W;
   localparam int CW       = acc_pkg::COUNT_W;

   // Link memory: bit AW is the cycle flag, the rest is the parent index.
   logic [AW:0]            link_mem [MAX_NODES];
   logic [AW:0]            rd_data_ff;
   logic                   mem_re;
   logic [AW-1:0]          mem_raddr;
   logic                   mem_we;
   logic [AW-1:0]          mem_waddr;
   logic [AW:0]            mem_wdata;

   acc_pkg::state_type     state_ff, state_in;
   logic [AW-1:0]          x_ff, x_in;
   logic [AW-1:0]          b_node_ff, b_node_in;
   logic                   side_ff, side_in;
   logic [AW-1:0]          ra_ff, ra_in;
   logic                   ra_cyc_ff, ra_cyc_in;
   logic [AW-1:0]          rb_ff, rb_in;
   logic                   rb_cyc_ff, rb_cyc_in;
   logic [CW-1:0]          merges_ff, merges_in;
   logic [CW-1:0]          cycles_ff, cycles_in;
   logic                   bad_ff, bad_in;
   logic [AW-1:0]          clr_ff, clr_in;
   logic [NW-1:0]          node_count_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [CW-1:0]          tree_count_ff, tree_count_in;
   logic                   bad_seen_ff, bad_seen_in;

   logic [NW-1:0]          n_eff;
   logic                   edge_bad;
   logic [CW:0]            used;
   logic [AW-1:0]          rd_parent;
   logic                   rd_cyc;

   assign csr_ready         = 1'b1;
   assign busy              = (state_ff != acc_pkg::ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_tree_count    = tree_count_ff;
   assign rsp_bad_edge_seen = bad_seen_ff;

   // Node count limited to the memory depth.
   assign n_eff = (node_count_ff > NW'(CAP)) ? NW'(CAP) : node_count_ff;

   // An endpoint of zero or above the node count makes the edge invalid.
   assign edge_bad = (req_node_a == '0) || (req_node_b == '0) ||
                     (req_node_a > n_eff) || (req_node_b > n_eff);

   // Nodes already absorbed by merges or by cyclic components.
   assign used = {1'b0, merges_ff} + {1'b0, cycles_ff};

   assign rd_parent = rd_data_ff[AW-1:0];
   assign rd_cyc    = rd_data_ff[AW];

   // Link memory write port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         link_mem[mem_waddr] <= mem_wdata;
      end
   end

   // Link memory read port with registered data.
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_data_ff <= link_mem[mem_raddr];
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         node_count_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         node_count_ff <= csr_node_count;
      end
   end

   // Control and counter registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= acc_pkg::ST_CLEAR;
         clr_ff       <= '0;
         merges_ff    <= '0;
         cycles_ff    <= '0;
         bad_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
         side_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         merges_ff    <= merges_in;
         cycles_ff    <= cycles_in;
         bad_ff       <= bad_in;
         rsp_valid_ff <= rsp_valid_in;
         side_ff      <= side_in;
      end
   end

   // Working registers of the root searches and the result word.
   always_ff @(posedge clock) begin
      x_ff          <= x_in;
      b_node_ff     <= b_node_in;
      ra_ff         <= ra_in;
      ra_cyc_ff     <= ra_cyc_in;
      rb_ff         <= rb_in;
      rb_cyc_ff     <= rb_cyc_in;
      tree_count_ff <= tree_count_in;
      bad_seen_ff   <= bad_seen_in;
   end

   // Sequencer: clearing pass, two root searches with path halving, update.
   always_comb begin
      state_in      = state_ff;
      x_in          = x_ff;
      b_node_in     = b_node_ff;
      side_in       = side_ff;
      ra_in         = ra_ff;
      ra_cyc_in     = ra_cyc_ff;
      rb_in         = rb_ff;
      rb_cyc_in     = rb_cyc_ff;
      merges_in     = merges_ff;
      cycles_in     = cycles_ff;
      bad_in        = bad_ff;
      clr_in        = clr_ff;
      rsp_valid_in  = 1'b0;
      tree_count_in = tree_count_ff;
      bad_seen_in   = bad_seen_ff;
      mem_re        = 1'b0;
      mem_raddr     = x_ff;
      mem_we        = 1'b0;
      mem_waddr     = x_ff;
      mem_wdata     = {1'b0, x_ff};

      case (state_ff)
         acc_pkg::ST_CLEAR: begin
            // Every node becomes its own root without a cycle.
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = {1'b0, clr_ff};
            clr_in    = clr_ff + AW'(1);
            if (clr_ff == AW'(MAX_NODES - 1)) begin
               clr_in   = '0;
               state_in = acc_pkg::ST_IDLE;
            end
         end

         acc_pkg::ST_IDLE: begin
            if (start) begin
               if (req_type == acc_pkg::REQ_END) begin
                  // The count never exceeds the node count; it is floored at zero if used exceeds it.
                  tree_count_in = (used > {1'b0, n_eff}) ? '0
                                  : CW'({1'b0, n_eff} - used);
                  bad_seen_in   = bad_ff;
                  rsp_valid_in  = 1'b1;
                  merges_in     = '0;
                  cycles_in     = '0;
                  bad_in        = 1'b0;
                  clr_in        = '0;
                  state_in      = acc_pkg::ST_CLEAR;
               end else if (edge_bad) begin
                  bad_in = 1'b1;
               end else begin
                  x_in      = AW'(req_node_a - NW'(1));
                  b_node_in = AW'(req_node_b - NW'(1));
                  side_in   = 1'b0;
                  mem_re    = 1'b1;
                  mem_raddr = AW'(req_node_a - NW'(1));
                  state_in  = acc_pkg::ST_FIND_P;
               end
            end
         end

         acc_pkg::ST_FIND_P: begin
            // The read data holds the entry of x.
            if (rd_parent == x_ff) begin
               if (!side_ff) begin
                  ra_in     = x_ff;
                  ra_cyc_in = rd_cyc;
                  side_in   = 1'b1;
                  x_in      = b_node_ff;
                  mem_re    = 1'b1;
                  mem_raddr = b_node_ff;
               end else begin
                  rb_in     = x_ff;
                  rb_cyc_in = rd_cyc;
                  state_in  = acc_pkg::ST_UPDATE;
               end
            end else begin
               mem_re    = 1'b1;
               mem_raddr = rd_parent;
               state_in  = acc_pkg::ST_FIND_GP;
            end
         end

         acc_pkg::ST_FIND_GP: begin
            // Path halving: link x to its grandparent and continue there.
            // The grandparent differs from x, so the read never meets the write.
            mem_we    = 1'b1;
            mem_waddr = x_ff;
            mem_wdata = {1'b0, rd_parent};
            x_in      = rd_parent;
            mem_re    = 1'b1;
            mem_raddr = rd_parent;
            state_in  = acc_pkg::ST_FIND_P;
         end

         acc_pkg::ST_UPDATE: begin
            if (ra_ff == rb_ff) begin
               // Both ends in one component: it now holds a cycle.
               if (!ra_cyc_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = ra_ff;
                  mem_wdata = {1'b1, ra_ff};
                  cycles_in = cycles_ff + CW'(1);
               end
               state_in = acc_pkg::ST_IDLE;
            end else begin
               // Merge: the root of b hangs below the root of a.
               mem_we    = 1'b1;
               mem_waddr = ra_ff;
               mem_wdata = {ra_cyc_ff | rb_cyc_ff, ra_ff};
               if (ra_cyc_ff && rb_cyc_ff) begin
                  cycles_in = cycles_ff - CW'(1);
               end
               merges_in = merges_ff + CW'(1);
               state_in  = acc_pkg::ST_LINK;
            end
         end

         acc_pkg::ST_LINK: begin
            mem_we    = 1'b1;
            mem_waddr = rb_ff;
            mem_wdata = {1'b0, ra_ff};
            state_in  = acc_pkg::ST_IDLE;
         end

         default: begin
            state_in = acc_pkg::ST_CLEAR;
            clr_in   = '0;
         end
      endcase
   end

endmodule

// ===== sv/acc_checker.sv =====
`include "acyclic_component_counter_macros.svh"

// Port-level checks of the acyclic component counter.
module acc_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_type,
   input logic rsp_valid
);

   logic end_taken;

   assign end_taken = start && !busy && (req_type == acc_pkg::REQ_END);

   // An end word produces its result in the next cycle.
   `ACC_ASSERT_NEXT(a_end_gives_result, end_taken, rsp_valid, "end word without result")

   // An end word starts the clearing pass.
   `ACC_ASSERT_NEXT(a_end_clears, end_taken, busy, "no clearing pass after end word")

   // A result lasts one cycle only.
   `ACC_ASSERT_NEXT(a_single_strobe, rsp_valid, !rsp_valid, "result strobe held")

   // A result only follows an accepted end word.
   `ACC_ASSERT_SAME(a_result_cause, rsp_valid, $past(end_taken), "result without end word")

endmodule

bind acyclic_component_counter acc_checker u_acc_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_type  (req_type),
   .rsp_valid (rsp_valid)
);
